// File: sv/linked_set_with_free_list_top_assert.svh
// assertion macros for the linked set block
// used by the sequencer; depends on nothing else
`ifndef LINKED_SET_WITH_FREE_LIST_TOP_ASSERT_SVH
`define LINKED_SET_WITH_FREE_LIST_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define LSFL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lsfl assertion failed");
// next-cycle implication
`define LSFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lsfl assertion failed");
`else
`define LSFL_ASSERT_NOW(label, clk, rst, ante, cons)
`define LSFL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: sv/lsfl_pkg.sv
// shared types and constants for the linked set with free list
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lsfl_pkg;

   localparam int ELEM_IN_W   = 32;
   localparam int COUNT_OUT_W = 7;

   // request item
   typedef struct packed {
      logic [1:0]                  req_type;
      logic signed [ELEM_IN_W-1:0] elem_value;
   } lsfl_req_type;

   // result item
   typedef struct packed {
      logic                   success;
      logic                   full_reject;
      logic [COUNT_OUT_W-1:0] member_count;
      logic                   empty_res;
   } lsfl_rsp_type;

   // write enables from sequencer to storage
   typedef struct packed {
      logic val_we;
      logic link_we;
   } lsfl_wen_type;

endpackage

`default_nettype wire

// File: sv/lsfl_store.sv
// slot storage: value memory and link memory, registered read
// depends on lsfl_pkg
`timescale 1ns / 1ps
`default_nettype none

module lsfl_store
   import lsfl_pkg::*;
#(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32,
   parameter int ADDR_W      = 6,
   parameter int SLOT_W      = 7
) (
   input  wire logic                   clock,
   input  wire lsfl_wen_type           wen,
   input  wire logic [ADDR_W-1:0]      rd_addr,
   input  wire logic [ADDR_W-1:0]      val_waddr,
   input  wire logic [VALUE_WIDTH-1:0] val_wdata,
   input  wire logic [ADDR_W-1:0]      link_waddr,
   input  wire logic [SLOT_W-1:0]      link_wdata,
   output logic      [VALUE_WIDTH-1:0] val_rd,
   output logic      [SLOT_W-1:0]      link_rd
);

   logic [VALUE_WIDTH-1:0] value_mem_ff [CAPACITY];
   logic [SLOT_W-1:0]      link_mem_ff  [CAPACITY];
   logic [VALUE_WIDTH-1:0] val_rd_ff;
   logic [SLOT_W-1:0]      link_rd_ff;

   // value memory, read before write
   always_ff @(posedge clock) begin
      if (wen.val_we) begin
         value_mem_ff[val_waddr] <= val_wdata;
      end
      val_rd_ff <= value_mem_ff[rd_addr];
   end

   // link memory, read before write
   always_ff @(posedge clock) begin
      if (wen.link_we) begin
         link_mem_ff[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem_ff[rd_addr];
   end

   assign val_rd  = val_rd_ff;
   assign link_rd = link_rd_ff;

endmodule

`default_nettype wire

// File: sv/lsfl_seq.sv
// sequencer: list walk, relinking, free list and count, result item
// depends on lsfl_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "linked_set_with_free_list_top_assert.svh"

module lsfl_seq
   import lsfl_pkg::*;
#(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32,
   parameter int ADDR_W      = 6,
   parameter int SLOT_W      = 7
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire lsfl_req_type           req_item,
   output logic                        rsp_valid,
   output lsfl_rsp_type                rsp_item,
   output lsfl_wen_type                wen,
   output logic      [ADDR_W-1:0]      rd_addr,
   output logic      [ADDR_W-1:0]      val_waddr,
   output logic      [VALUE_WIDTH-1:0] val_wdata,
   output logic      [ADDR_W-1:0]      link_waddr,
   output logic      [SLOT_W-1:0]      link_wdata,
   input  wire logic [VALUE_WIDTH-1:0] val_rd,
   input  wire logic [SLOT_W-1:0]      link_rd
);

   localparam int CNT_W = SLOT_W;
   localparam logic [SLOT_W-1:0] NIL = SLOT_W'(CAPACITY);
   localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(CAPACITY);

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_FIXUP = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [1:0]             op_ff, op_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [SLOT_W-1:0]      list_head_ff, list_head_in;
   logic [SLOT_W-1:0]      free_head_ff, free_head_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [CNT_W-1:0]       held_count_ff, held_count_in;
   logic [SLOT_W-1:0]      cur_ff, cur_in;
   logic [SLOT_W-1:0]      prev_ff, prev_in;
   logic [CNT_W-1:0]       steps_ff, steps_in;
   logic [SLOT_W-1:0]      next_ff, next_in;
   logic                   ok_ff, ok_in;
   logic                   full_ff, full_in;

   logic signed [63:0]     elem_ext;
   logic                   cur_ok;
   logic                   bound_hit;
   logic                   hit;
   logic                   walk_end;
   logic                   free_ok;

   // value as stored: sign-extended then cut to the value width
   assign elem_ext = 64'(req_item.elem_value);

   // walk status for the slot whose data is in the read registers
   assign cur_ok    = cur_ff < NIL;
   assign bound_hit = steps_ff == CNT_FULL;
   assign hit       = cur_ok && !bound_hit && (val_rd == value_ff);
   assign walk_end  = !cur_ok || bound_hit || hit;
   assign free_ok   = free_head_ff < NIL;

   // next-state and memory access logic
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      list_head_in  = list_head_ff;
      free_head_in  = free_head_ff;
      fill_in       = fill_ff;
      held_count_in = held_count_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      steps_in      = steps_ff;
      next_in       = next_ff;
      ok_in         = ok_ff;
      full_in       = full_ff;
      wen.val_we    = 1'b0;
      wen.link_we   = 1'b0;
      rd_addr       = list_head_ff[ADDR_W-1:0];
      val_waddr     = free_head_ff[ADDR_W-1:0];
      val_wdata     = value_ff;
      link_waddr    = free_head_ff[ADDR_W-1:0];
      link_wdata    = list_head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_item.req_type;
               value_in = elem_ext[VALUE_WIDTH-1:0];
               cur_in   = list_head_ff;
               prev_in  = NIL;
               steps_in = '0;
               ok_in    = 1'b0;
               full_in  = 1'b0;
               if (req_item.req_type == OP_NONE) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            if (!walk_end) begin
               // advance one slot, reading the next one straight away
               cur_in   = link_rd;
               prev_in  = cur_ff;
               steps_in = steps_ff + CNT_W'(1);
               rd_addr  = link_rd[ADDR_W-1:0];
            end else begin
               rd_addr  = free_head_ff[ADDR_W-1:0];
               next_in  = link_rd;
               state_in = ST_DONE;
               case (op_ff)
                  OP_ADD: begin
                     if (hit) begin
                        ok_in = 1'b0;
                     end else if (!free_ok) begin
                        full_in = 1'b1;
                     end else begin
                        // take the free head and link it at the list head
                        wen.val_we    = 1'b1;
                        wen.link_we   = 1'b1;
                        list_head_in  = free_head_ff;
                        held_count_in = held_count_ff + CNT_W'(1);
                        ok_in         = 1'b1;
                        if (free_head_ff == fill_ff) begin
                           // never-used slot: its successor is the next one
                           free_head_in = free_head_ff + SLOT_W'(1);
                           fill_in      = fill_ff + CNT_W'(1);
                        end else begin
                           state_in = ST_FIXUP;
                        end
                     end
                  end
                  OP_REMOVE: begin
                     if (hit) begin
                        // push the slot onto the free list
                        wen.link_we  = 1'b1;
                        link_waddr   = cur_ff[ADDR_W-1:0];
                        link_wdata   = free_head_ff;
                        free_head_in = cur_ff;
                        ok_in        = 1'b1;
                        if (held_count_ff != '0) begin
                           held_count_in = held_count_ff - CNT_W'(1);
                        end
                        if (prev_ff == NIL) begin
                           list_head_in = link_rd;
                        end else begin
                           state_in = ST_FIXUP;
                        end
                     end
                  end
                  OP_SEARCH: begin
                     ok_in = hit;
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end

         ST_FIXUP: begin
            if (op_ff == OP_ADD) begin
               // old link of the taken slot becomes the free head
               free_head_in = link_rd;
            end else begin
               // bypass the removed slot
               wen.link_we = 1'b1;
               link_waddr  = prev_ff[ADDR_W-1:0];
               link_wdata  = next_ff;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         list_head_ff  <= NIL;
         free_head_ff  <= '0;
         fill_ff       <= '0;
         held_count_ff <= '0;
      end else begin
         state_ff      <= state_in;
         list_head_ff  <= list_head_in;
         free_head_ff  <= free_head_in;
         fill_ff       <= fill_in;
         held_count_ff <= held_count_in;
      end
   end

   // per-item working registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      value_ff <= value_in;
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      steps_ff <= steps_in;
      next_ff  <= next_in;
      ok_ff    <= ok_in;
      full_ff  <= full_in;
   end

   // handshake and result item
   assign busy                  = state_ff != ST_IDLE;
   assign rsp_valid             = state_ff == ST_DONE;
   assign rsp_item.success      = ok_ff;
   assign rsp_item.full_reject  = full_ff;
   assign rsp_item.member_count = COUNT_OUT_W'(held_count_ff);
   assign rsp_item.empty_res    = held_count_ff == '0;

   // checks
   `LSFL_ASSERT_NOW(a_full_means_count, clock, reset, rsp_valid && full_ff, held_count_ff == CNT_FULL)
   `LSFL_ASSERT_NOW(a_ok_or_full, clock, reset, rsp_valid, !(ok_ff && full_ff))
   `LSFL_ASSERT_NOW(a_free_nil_iff_full, clock, reset, state_ff == ST_IDLE, (free_head_ff == NIL) == (held_count_ff == CNT_FULL))
   `LSFL_ASSERT_NOW(a_walk_bound, clock, reset, state_ff == ST_WALK, steps_ff <= CNT_FULL)
   `LSFL_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)

endmodule

`default_nettype wire

// File: sv/linked_set_with_free_list_top.sv
// Linked set with free list. A walk over the list does one slot compare per cycle, fed
// by the registered memory read, and is bounded by CAPACITY steps; a second link write
// or free-head fetch adds the FIXUP state before the result strobe. The block takes no
// new item until the current one has its result (busy is high until then). Reset:
// synchronous, empty set, no clearing pass; unused slots follow a fill count. The result
// is on the rsp ports for one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none

module linked_set_with_free_list_top
   import lsfl_pkg::*;
#(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire lsfl_req_type req_item,
   output logic              rsp_valid,
   output lsfl_rsp_type      rsp_item
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int SLOT_W = $clog2(CAPACITY + 1);

   lsfl_wen_type           wen;
   logic [ADDR_W-1:0]      rd_addr;
   logic [ADDR_W-1:0]      val_waddr;
   logic [VALUE_WIDTH-1:0] val_wdata;
   logic [ADDR_W-1:0]      link_waddr;
   logic [SLOT_W-1:0]      link_wdata;
   logic [VALUE_WIDTH-1:0] val_rd;
   logic [SLOT_W-1:0]      link_rd;

   // sequencer
   lsfl_seq #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH),
      .ADDR_W      (ADDR_W),
      .SLOT_W      (SLOT_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .wen        (wen),
      .rd_addr    (rd_addr),
      .val_waddr  (val_waddr),
      .val_wdata  (val_wdata),
      .link_waddr (link_waddr),
      .link_wdata (link_wdata),
      .val_rd     (val_rd),
      .link_rd    (link_rd)
   );

   // slot storage
   lsfl_store #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH),
      .ADDR_W      (ADDR_W),
      .SLOT_W      (SLOT_W)
   ) u_store (
      .clock      (clock),
      .wen        (wen),
      .rd_addr    (rd_addr),
      .val_waddr  (val_waddr),
      .val_wdata  (val_wdata),
      .link_waddr (link_waddr),
      .link_wdata (link_wdata),
      .val_rd     (val_rd),
      .link_rd    (link_rd)
   );

endmodule

`default_nettype wire

// File: test/lsfl_tb_pkg.sv
// request codes shared by the linked set testbench and its scoreboard
// no dependencies
`timescale 1ns / 1ps

package lsfl_tb_pkg;

   // request codes carried in req_type
   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_UNUSED = 2'd3
   } set_op_e;

endpackage

// File: test/lsfl_scoreboard.sv
// scoreboard for the linked set block: keeps its own copy of the set and the free list,
// predicts each result and compares it with the block's output
// depends on lsfl_pkg and lsfl_tb_pkg
`timescale 1ns / 1ps

module lsfl_scoreboard
   import lsfl_pkg::*;
   import lsfl_tb_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic         busy,
   input  wire lsfl_req_type req_item,
   input  wire logic         rsp_valid,
   input  wire lsfl_rsp_type rsp_item,
   output int                fail_count,
   output int                pending,
   output int                rsp_count,
   output int                hit_count,
   output int                full_count
);

   localparam int NIL_SLOT = CAPACITY;

   // shadow of the slot store, the two list heads and the count
   logic [ELEM_IN_W-1:0] slot_value [CAPACITY];
   int                   slot_link  [CAPACITY];
   int                   list_head;
   int                   free_head;
   int                   held;

   // results still owed by the block, oldest first
   lsfl_rsp_type         owed_q [$];

   // empty set, every slot chained on the free list
   function automatic void clear_set();
      int i;
      for (i = 0; i < CAPACITY; i++) begin
         slot_value[i] = '0;
         slot_link[i]  = i + 1;
      end
      slot_link[CAPACITY-1] = NIL_SLOT;
      list_head = NIL_SLOT;
      free_head = 0;
      held      = 0;
   endfunction

   // apply one request to the shadow set and return the result it should give
   function automatic lsfl_rsp_type apply_request(input lsfl_req_type rq);
      set_op_e      op;
      int           cur;
      int           prev;
      int           hit;
      int           steps;
      int           s;
      lsfl_rsp_type r;
      op    = set_op_e'(rq.req_type);
      cur   = list_head;
      prev  = NIL_SLOT;
      hit   = NIL_SLOT;
      steps = 0;
      r     = '0;
      // walk the list, bounded by the number of slots
      while (cur < CAPACITY && steps < CAPACITY && hit == NIL_SLOT) begin
         if (slot_value[cur] == rq.elem_value) begin
            hit = cur;
         end else begin
            prev = cur;
            cur  = slot_link[cur];
            steps++;
         end
      end
      case (op)
         OP_ADD: begin
            // duplicates leave the set alone; a new value needs a free slot
            if (hit == NIL_SLOT) begin
               if (free_head >= CAPACITY) begin
                  r.full_reject = 1'b1;
               end else begin
                  s             = free_head;
                  slot_value[s] = rq.elem_value;
                  free_head     = slot_link[s];
                  slot_link[s]  = list_head;
                  list_head     = s;
                  held++;
                  r.success     = 1'b1;
               end
            end
         end
         OP_REMOVE: begin
            // unlink the slot and push it onto the free list
            if (hit != NIL_SLOT) begin
               if (prev == NIL_SLOT) begin
                  list_head = slot_link[hit];
               end else begin
                  slot_link[prev] = slot_link[hit];
               end
               slot_link[hit] = free_head;
               free_head      = hit;
               if (held > 0) begin
                  held--;
               end
               r.success = 1'b1;
            end
         end
         OP_SEARCH: begin
            r.success = (hit != NIL_SLOT);
         end
         default: begin
         end
      endcase
      r.member_count = COUNT_OUT_W'(held);
      r.empty_res    = (held == 0);
      return r;
   endfunction

   task automatic report_field(input string field, input logic [COUNT_OUT_W-1:0] want,
                               input logic [COUNT_OUT_W-1:0] got);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
   endtask

   // watch both channels at each rising edge
   always @(posedge clock) begin : watch
      lsfl_rsp_type want;
      int           bad;
      bad = 0;
      if (reset) begin
         clear_set();
         owed_q.delete();
         fail_count <= 0;
         pending    <= 0;
         rsp_count  <= 0;
         hit_count  <= 0;
         full_count <= 0;
      end else begin
         // a result leaves in the cycle it is strobed
         if (rsp_valid === 1'b1) begin
            if (owed_q.size() == 0) begin
               $display("%0t: result with no item outstanding, expected none, got %p",
                        $time, rsp_item);
               bad++;
            end else begin
               want = owed_q.pop_front();
               if (rsp_item.success !== want.success) begin
                  report_field("success", want.success, rsp_item.success);
                  bad++;
               end
               if (rsp_item.full_reject !== want.full_reject) begin
                  report_field("full_reject", want.full_reject, rsp_item.full_reject);
                  bad++;
               end
               if (rsp_item.member_count !== want.member_count) begin
                  report_field("member_count", want.member_count, rsp_item.member_count);
                  bad++;
               end
               if (rsp_item.empty_res !== want.empty_res) begin
                  report_field("empty_res", want.empty_res, rsp_item.empty_res);
                  bad++;
               end
               hit_count  <= hit_count + want.success;
               full_count <= full_count + want.full_reject;
            end
            rsp_count <= rsp_count + 1;
         end
         // an item is taken when start meets an idle block
         if (start === 1'b1 && busy === 1'b0) begin
            owed_q.push_back(apply_request(req_item));
         end
         fail_count <= fail_count + bad;
         pending    <= owed_q.size();
      end
   end

endmodule

// File: test/tb_linked_set_with_free_list_top.sv
// testbench top for the linked set block: clock, reset, directed and random requests
// under several idling patterns; checking is done by lsfl_scoreboard
// depends on lsfl_pkg, lsfl_tb_pkg, lsfl_scoreboard and linked_set_with_free_list_top
`timescale 1ns / 1ps

module tb_linked_set_with_free_list_top;
   import lsfl_pkg::*;
   import lsfl_tb_pkg::*;

   localparam int CAPACITY     = 64;
   localparam int POOL_N       = 80;
   localparam int RANDOM_ITEMS = 1500;
   localparam int PHASE_LEN    = 125;

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   lsfl_req_type req_item = '0;
   logic         busy;
   logic         rsp_valid;
   lsfl_rsp_type rsp_item;

   int           fail_count;
   int           pending;
   int           rsp_count;
   int           hit_count;
   int           full_count;

   // values reused so that adds, removes and searches meet each other
   logic [31:0]  pool [POOL_N];
   int           idle_pct = 0;
   int           sent     = 0;

   always #5 clock = ~clock;

   linked_set_with_free_list_top #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (32)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   lsfl_scoreboard #(
      .CAPACITY (CAPACITY)
   ) u_scoreboard (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .fail_count (fail_count),
      .pending    (pending),
      .rsp_count  (rsp_count),
      .hit_count  (hit_count),
      .full_count (full_count)
   );

   // offer one item, with an optional gap first, and return once it is taken
   task automatic drive_item(input set_op_e op, input logic [31:0] value);
      int           gap;
      lsfl_req_type it;
      it.req_type   = op;
      it.elem_value = value;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         gap = ($urandom_range(3) == 0) ? $urandom_range(80, 1) : $urandom_range(6, 1);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy !== 1'b0);
      sent++;
   endtask

   // hold off until every outstanding item has its result
   task automatic settle();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // mostly pool values, sometimes any 32-bit pattern
   function automatic logic [31:0] pick_value();
      if ($urandom_range(99) < 15) begin
         return $urandom();
      end
      return pool[$urandom_range(POOL_N-1)];
   endfunction

   initial begin : stimulus
      int          ph;
      int          n;
      int          roll;
      int          fill_idx;
      int          drain_idx;
      int          levels [3];
      set_op_e     op;
      logic [31:0] v;
      levels    = '{0, 80, 17};
      fill_idx  = 0;
      drain_idx = 0;
      for (n = 0; n < POOL_N; n++) begin
         pool[n] = $urandom();
      end
      pool[0] = 32'h8000_0000;
      pool[1] = 32'h7fff_ffff;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty set, extremes, duplicate, head/middle/tail removal, unused code
      drive_item(OP_SEARCH, 32'h0000_0000);
      drive_item(OP_REMOVE, 32'h0000_0005);
      drive_item(OP_UNUSED, 32'h7fff_ffff);
      drive_item(OP_ADD,    32'h8000_0000);
      drive_item(OP_ADD,    32'h7fff_ffff);
      drive_item(OP_ADD,    32'h0000_0000);
      drive_item(OP_ADD,    32'hffff_ffff);
      drive_item(OP_ADD,    32'hffff_ffff);
      drive_item(OP_SEARCH, 32'h8000_0000);
      drive_item(OP_SEARCH, 32'h0000_0001);
      drive_item(OP_REMOVE, 32'h0000_0000);
      drive_item(OP_REMOVE, 32'hffff_ffff);
      drive_item(OP_REMOVE, 32'h8000_0000);
      drive_item(OP_REMOVE, 32'h8000_0000);
      drive_item(OP_UNUSED, 32'hffff_ffff);
      drive_item(OP_SEARCH, 32'h7fff_ffff);
      drive_item(OP_REMOVE, 32'h7fff_ffff);
      drive_item(OP_ADD,    32'h5555_5555);
      drive_item(OP_ADD,    32'haaaa_aaaa);
      drive_item(OP_REMOVE, 32'h5555_5555);
      drive_item(OP_SEARCH, 32'haaaa_aaaa);
      drive_item(OP_REMOVE, 32'haaaa_aaaa);
      settle();

      // random phases: mixed traffic, filling to capacity and draining, each
      // under every idling level
      for (ph = 0; ph < RANDOM_ITEMS / PHASE_LEN; ph++) begin
         idle_pct = levels[(ph + ph / 3) % 3];
         for (n = 0; n < PHASE_LEN; n++) begin
            roll = $urandom_range(99);
            case (ph % 3)
               1: begin
                  // fill: walk the pool with adds, wrapping round into duplicates
                  if (roll < 90) begin
                     op       = OP_ADD;
                     v        = pool[fill_idx];
                     fill_idx = (fill_idx + 1) % POOL_N;
                  end else begin
                     op = (roll < 95) ? OP_SEARCH : OP_REMOVE;
                     v  = pick_value();
                  end
               end
               2: begin
                  // drain: remove pool values in turn
                  if (roll < 90) begin
                     op        = OP_REMOVE;
                     v         = pool[drain_idx];
                     drain_idx = (drain_idx + 1) % POOL_N;
                  end else begin
                     op = (roll < 95) ? OP_SEARCH : OP_ADD;
                     v  = pick_value();
                  end
               end
               default: begin
                  if (roll < 40) begin
                     op = OP_ADD;
                  end else if (roll < 70) begin
                     op = OP_REMOVE;
                  end else if (roll < 95) begin
                     op = OP_SEARCH;
                  end else begin
                     op = OP_UNUSED;
                  end
                  v = pick_value();
               end
            endcase
            drive_item(op, v);
         end
         settle();
      end

      // let any stray result show up
      repeat (CAPACITY + 16) @(posedge clock);
      $display("%0d items sent, %0d results checked", sent, rsp_count);
      $display("%0d requests succeeded, %0d adds turned away on a full set",
               hit_count, full_count);
      if (fail_count == 0) begin
         $display("tb_linked_set_with_free_list_top passed");
      end else begin
         $display("tb_linked_set_with_free_list_top failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("tb_linked_set_with_free_list_top failed");
      $finish;
   end

endmodule

// File: linked_set_with_free_list_top.f
+incdir+sv
sv/lsfl_pkg.sv
sv/lsfl_store.sv
sv/lsfl_seq.sv
sv/linked_set_with_free_list_top.sv
test/lsfl_tb_pkg.sv
test/lsfl_scoreboard.sv
test/tb_linked_set_with_free_list_top.sv
